// ===== design/mtg_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtg_pkg: shared types and constants of the mesh tangent generator
// Command encoding passed from the front end to the back end, field widths and
// the widths of the shared divider.
// ----------------------------------------------------------------------------
package mtg_pkg;

  localparam int IDX_W = 12;
  localparam int POS_W = 32;
  localparam int TEX_W = 24;
  localparam int NRM_W = 16;
  localparam int ACC_W = 48;
  localparam int TAN_W = 16;

  // Shared long divider: dividend and divisor widths.
  localparam int DVD_W = 82;
  localparam int DVS_W = 51;

  // Integer square root: radicand and root widths.
  localparam int SQ_W = 64;
  localparam int RT_W = 32;

  typedef enum logic [1:0] {
    FN_LOAD = 2'd0,
    FN_FACE = 2'd1,
    FN_READ = 2'd2,
    FN_NONE = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    OP_LOAD     = 2'd0,
    OP_FACE     = 2'd1,
    OP_READ     = 2'd2,
    OP_READ_BAD = 2'd3
  } op_t;

  typedef struct packed {
    op_t                       op;
    logic [IDX_W-1:0]          idx_a;
    logic [IDX_W-1:0]          idx_b;
    logic [IDX_W-1:0]          idx_c;
    logic signed [POS_W-1:0]   pos_x;
    logic signed [POS_W-1:0]   pos_y;
    logic signed [POS_W-1:0]   pos_z;
    logic signed [TEX_W-1:0]   tex_u;
    logic signed [TEX_W-1:0]   tex_v;
    logic signed [NRM_W-1:0]   nrm_x;
    logic signed [NRM_W-1:0]   nrm_y;
    logic signed [NRM_W-1:0]   nrm_z;
  } cmd_t;

endpackage

// ===== design/mtg_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtg_front: input acceptance, classification and command queue
// Range-checks the vertex indexes, drops beats that have no effect and keeps
// up to two decoded commands for the back end.
// ----------------------------------------------------------------------------
module mtg_front #(
  parameter int VERTS = 4096
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [1:0]                         in_func,
  input  logic [mtg_pkg::IDX_W-1:0]          in_idx_a,
  input  logic [mtg_pkg::IDX_W-1:0]          in_idx_b,
  input  logic [mtg_pkg::IDX_W-1:0]          in_idx_c,
  input  logic signed [mtg_pkg::POS_W-1:0]   in_pos_x,
  input  logic signed [mtg_pkg::POS_W-1:0]   in_pos_y,
  input  logic signed [mtg_pkg::POS_W-1:0]   in_pos_z,
  input  logic signed [mtg_pkg::TEX_W-1:0]   in_tex_u,
  input  logic signed [mtg_pkg::TEX_W-1:0]   in_tex_v,
  input  logic signed [mtg_pkg::NRM_W-1:0]   in_nrm_x,
  input  logic signed [mtg_pkg::NRM_W-1:0]   in_nrm_y,
  input  logic signed [mtg_pkg::NRM_W-1:0]   in_nrm_z,
  input  logic                               clear_busy,
  output logic                               q_valid,
  output mtg_pkg::cmd_t                      q_cmd,
  input  logic                               q_pop
);
  import mtg_pkg::*;

  cmd_t       fifo_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  logic ok_a, ok_b, ok_c, keep, push;
  cmd_t cmd;

  always_comb begin
    ok_a = 32'(in_idx_a) < VERTS;
    ok_b = 32'(in_idx_b) < VERTS;
    ok_c = 32'(in_idx_c) < VERTS;
    cmd.idx_a = in_idx_a;
    cmd.idx_b = in_idx_b;
    cmd.idx_c = in_idx_c;
    cmd.pos_x = in_pos_x;
    cmd.pos_y = in_pos_y;
    cmd.pos_z = in_pos_z;
    cmd.tex_u = in_tex_u;
    cmd.tex_v = in_tex_v;
    cmd.nrm_x = in_nrm_x;
    cmd.nrm_y = in_nrm_y;
    cmd.nrm_z = in_nrm_z;
    cmd.op    = OP_LOAD;
    keep      = 1'b0;
    unique case (func_t'(in_func))
      FN_LOAD: begin
        cmd.op = OP_LOAD;
        keep   = ok_a;
      end
      FN_FACE: begin
        cmd.op = OP_FACE;
        keep   = ok_a && ok_b && ok_c;
      end
      FN_READ: begin
        cmd.op = ok_a ? OP_READ : OP_READ_BAD;
        keep   = 1'b1;
      end
      FN_NONE: begin
        keep = 1'b0;
      end
      default: keep = 1'b0;
    endcase
  end

  assign in_ready = !clear_busy && (cnt_r != 2'd2);
  assign push     = in_valid && in_ready && keep;
  assign q_valid  = cnt_r != 2'd0;
  assign q_cmd    = fifo_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = q_pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(push) - 2'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r] <= cmd;
    end
  end

endmodule

// ===== design/mtg_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtg_div: unsigned restoring divider, one quotient bit per cycle
// Shared by the face direction and the tangent normalization.
// ----------------------------------------------------------------------------
module mtg_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [mtg_pkg::DVD_W-1:0]   dividend,
  input  logic [mtg_pkg::DVS_W-1:0]   divisor,
  output logic                        done,
  output logic [mtg_pkg::DVD_W-1:0]   quotient
);
  import mtg_pkg::*;

  localparam int CW = $clog2(DVD_W + 1);

  logic             busy_r, done_r;
  logic [CW-1:0]    cnt_r;
  logic [DVD_W-1:0] dvd_r;
  logic [DVS_W-1:0] dvs_r;
  logic [DVS_W-1:0] rem_r;

  logic [DVS_W:0]   rem_sh;
  logic [DVS_W+1:0] diff;
  logic             ge;

  always_comb begin
    rem_sh = {rem_r, dvd_r[DVD_W-1]};
    diff   = {1'b0, rem_sh} - {2'b00, dvs_r};
    ge     = !diff[DVS_W+1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (busy_r) begin
        dvd_r <= {dvd_r[DVD_W-2:0], ge};
        rem_r <= ge ? diff[DVS_W-1:0] : rem_sh[DVS_W-1:0];
        if (cnt_r == CW'(DVD_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r + 1'b1;
        end
      end else if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        dvd_r  <= dividend;
        dvs_r  <= divisor;
        rem_r  <= '0;
      end
    end
  end

  assign done     = done_r;
  assign quotient = dvd_r;

endmodule

// ===== design/mtg_isqrt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtg_isqrt: floor integer square root, one root bit per cycle
// Digit-by-digit method over bit pairs of the radicand.
// ----------------------------------------------------------------------------
module mtg_isqrt (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [mtg_pkg::SQ_W-1:0]   value,
  output logic                       done,
  output logic [mtg_pkg::RT_W-1:0]   root
);
  import mtg_pkg::*;

  localparam int CW = $clog2(RT_W);

  logic            busy_r, done_r;
  logic [CW-1:0]   cnt_r;
  logic [SQ_W-1:0] v_r, r_r, b_r;
  logic [SQ_W-1:0] rb;

  assign rb = r_r + b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (busy_r) begin
        if (v_r >= rb) begin
          v_r <= v_r - rb;
          r_r <= (r_r >> 1) + b_r;
        end else begin
          r_r <= r_r >> 1;
        end
        b_r <= b_r >> 2;
        if (cnt_r == CW'(RT_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r + 1'b1;
        end
      end else if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        v_r    <= value;
        r_r    <= '0;
        b_r    <= SQ_W'(1) << (SQ_W - 2);
      end
    end
  end

  assign done = done_r;
  assign root = r_r[RT_W-1:0];

endmodule

// ===== design/mtg_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtg_back: vertex stores, accumulators and the tangent sequencer
// Executes queued commands: vertex loads, face accumulation and tangent reads,
// and holds the result register.
// ----------------------------------------------------------------------------
module mtg_back #(
  parameter int VERTS = 4096
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               q_valid,
  input  mtg_pkg::cmd_t                      q_cmd,
  output logic                               q_pop,
  output logic                               clear_busy,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [mtg_pkg::IDX_W-1:0]          out_vert_index,
  output logic signed [mtg_pkg::TAN_W-1:0]   out_tan_x,
  output logic signed [mtg_pkg::TAN_W-1:0]   out_tan_y,
  output logic signed [mtg_pkg::TAN_W-1:0]   out_tan_z,
  output logic                               out_is_zero
);
  import mtg_pkg::*;

  localparam int AW = $clog2(VERTS);

  typedef enum logic [4:0] {
    S_CLR, S_IDLE,
    S_FA, S_FB, S_FC, S_FDEN1, S_FDEN2, S_FNUM1, S_FNUM2, S_FDIV,
    S_FACC_RD, S_FACC_WR,
    S_RD, S_RDOT, S_RDCL, S_RPRJ, S_RMAX, S_RNRM, S_RSQ,
    S_RSQRT_S, S_RSQRT_W, S_RDIVS, S_RDIVW, S_OUT
  } state_t;

  function automatic logic signed [ACC_W-1:0] sat48(input logic signed [52:0] x);
    logic signed [ACC_W-1:0] y;
    if (x > 53'sh0_7FFF_FFFF_FFFF) y = 48'sh7FFF_FFFF_FFFF;
    else if (x < -53'sh0_8000_0000_0000) y = 48'sh8000_0000_0000;
    else y = x[ACC_W-1:0];
    return y;
  endfunction

  // Memories.
  logic [3*POS_W-1:0] pos_mem [VERTS];
  logic [2*TEX_W-1:0] tex_mem [VERTS];
  logic [3*NRM_W-1:0] nrm_mem [VERTS];
  logic [3*ACC_W-1:0] acc_mem [VERTS];
  logic [3*POS_W-1:0] rd_pos_r;
  logic [2*TEX_W-1:0] rd_tex_r;
  logic [3*NRM_W-1:0] rd_nrm_r;
  logic [3*ACC_W-1:0] rd_acc_r;

  state_t        state_r;
  logic [AW-1:0] clr_cnt_r;
  logic [1:0]    k_r;
  logic [AW-1:0] idx_a_r, idx_b_r, idx_c_r;
  logic [IDX_W-1:0] vidx_r;

  // Face datapath.
  logic signed [POS_W-1:0] pa_r [3];
  logic signed [TEX_W-1:0] ua_r, va_r;
  logic signed [POS_W:0]   e1_r [3];
  logic signed [POS_W:0]   e2_r [3];
  logic signed [TEX_W:0]   s1_r, t1_r, s2_r, t2_r;
  logic signed [49:0]      p1_r, p2_r;
  logic signed [50:0]      den_r;
  logic signed [57:0]      mn1_r, mn2_r;
  logic                    neg_r;
  logic signed [ACC_W-1:0] dir_r [3];

  // Read datapath.
  logic signed [ACC_W-1:0] t_r [3];
  logic signed [NRM_W-1:0] n_r [3];
  logic signed [51:0]      dacc_r;
  logic signed [ACC_W-1:0] d_r;
  logic signed [50:0]      o_r [3];
  logic [50:0]             m_r [3];
  logic [61:0]             sum_r;
  logic [RT_W-1:0]         len_r;
  logic signed [TAN_W-1:0] res_r [3];
  logic                    zero_r;

  // Output register.
  logic                    out_valid_r;
  logic [IDX_W-1:0]        out_idx_r;
  logic signed [TAN_W-1:0] out_tan_r [3];
  logic                    out_zero_r;

  // Combinational helpers.
  logic [AW-1:0]      ra, corner, acc_wa;
  logic               ld_we, acc_we;
  logic [3*ACC_W-1:0] acc_wd;
  logic signed [50:0] den_c;
  logic signed [58:0] num_c;
  logic [58:0]        num_mag;
  logic [50:0]        den_mag;
  logic signed [63:0] prod_c;
  logic signed [63:0] proj_c;
  logic [50:0]        mx;
  logic               div_start, div_done, sq_start, sq_done;
  logic [DVD_W-1:0]   div_dvd, div_q;
  logic [DVS_W-1:0]   div_dvs;
  logic [RT_W-1:0]    sq_root;
  logic [46:0]        qs;
  logic [ACC_W-1:0]   dir_c;

  always_comb begin
    unique case (k_r)
      2'd0:    corner = idx_a_r;
      2'd1:    corner = idx_b_r;
      default: corner = idx_c_r;
    endcase
    unique case (state_r)
      S_IDLE:    ra = AW'(q_cmd.idx_a);
      S_FA:      ra = idx_b_r;
      S_FB:      ra = idx_c_r;
      S_FACC_RD: ra = corner;
      default:   ra = idx_a_r;
    endcase
  end

  assign q_pop      = (state_r == S_IDLE) && q_valid;
  assign clear_busy = state_r == S_CLR;
  assign ld_we      = q_pop && (q_cmd.op == OP_LOAD);
  assign acc_we     = (state_r == S_CLR) || (state_r == S_FACC_WR);
  assign acc_wa     = (state_r == S_CLR) ? clr_cnt_r : corner;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      acc_wd[j*ACC_W +: ACC_W] = (state_r == S_CLR) ? '0 :
        sat48(53'($signed(rd_acc_r[j*ACC_W +: ACC_W])) + 53'(dir_r[j]));
    end
  end

  always_ff @(posedge clk) begin
    if (ld_we) begin
      pos_mem[AW'(q_cmd.idx_a)] <= {q_cmd.pos_z, q_cmd.pos_y, q_cmd.pos_x};
      tex_mem[AW'(q_cmd.idx_a)] <= {q_cmd.tex_v, q_cmd.tex_u};
      nrm_mem[AW'(q_cmd.idx_a)] <= {q_cmd.nrm_z, q_cmd.nrm_y, q_cmd.nrm_x};
    end
    rd_pos_r <= pos_mem[ra];
    rd_tex_r <= tex_mem[ra];
    rd_nrm_r <= nrm_mem[ra];
  end

  always_ff @(posedge clk) begin
    if (acc_we) begin
      acc_mem[acc_wa] <= acc_wd;
    end
    rd_acc_r <= acc_mem[ra];
  end

  always_comb begin
    den_c   = 51'(p1_r) - 51'(p2_r);
    num_c   = 59'(mn1_r) - 59'(mn2_r);
    num_mag = num_c[58] ? -num_c : num_c;
    den_mag = den_r[50] ? -den_r : den_r;
    prod_c  = n_r[k_r] * t_r[k_r];
    proj_c  = n_r[k_r] * d_r;
    mx      = m_r[0];
    if (m_r[1] > mx) mx = m_r[1];
    if (m_r[2] > mx) mx = m_r[2];
    qs      = (|div_q[DVD_W-1:47]) ? '1 : div_q[46:0];
    dir_c   = neg_r ? -48'(qs) : 48'(qs);
    div_start = (state_r == S_FNUM2) || (state_r == S_RDIVS);
    if (state_r == S_FNUM2) begin
      div_dvd = {num_mag[57:0], 24'd0};
      div_dvs = den_mag;
    end else begin
      div_dvd = DVD_W'({m_r[k_r][29:0], 14'd0}) + DVD_W'(len_r >> 1);
      div_dvs = DVS_W'(len_r);
    end
    sq_start = state_r == S_RSQRT_S;
  end

  mtg_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quotient (div_q)
  );

  mtg_isqrt u_isqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sq_start),
    .value (SQ_W'(sum_r)),
    .done  (sq_done),
    .root  (sq_root)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_cnt_r   <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // In S_OUT the output register is reloaded below instead.
      if (out_valid_r && out_ready && (state_r != S_OUT)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_CLR: begin
          if (clr_cnt_r == AW'(VERTS - 1)) begin
            state_r <= S_IDLE;
          end else begin
            clr_cnt_r <= clr_cnt_r + 1'b1;
          end
        end
        S_IDLE: begin
          if (q_valid) begin
            idx_a_r <= AW'(q_cmd.idx_a);
            idx_b_r <= AW'(q_cmd.idx_b);
            idx_c_r <= AW'(q_cmd.idx_c);
            vidx_r  <= q_cmd.idx_a;
            unique case (q_cmd.op)
              OP_LOAD: state_r <= S_IDLE;
              OP_FACE: state_r <= S_FA;
              OP_READ: state_r <= S_RD;
              OP_READ_BAD: begin
                for (int j = 0; j < 3; j++) res_r[j] <= '0;
                zero_r  <= 1'b1;
                state_r <= S_OUT;
              end
              default: state_r <= S_IDLE;
            endcase
          end
        end
        S_FA: begin
          for (int j = 0; j < 3; j++) pa_r[j] <= $signed(rd_pos_r[j*POS_W +: POS_W]);
          ua_r    <= $signed(rd_tex_r[TEX_W-1:0]);
          va_r    <= $signed(rd_tex_r[2*TEX_W-1:TEX_W]);
          state_r <= S_FB;
        end
        S_FB: begin
          for (int j = 0; j < 3; j++) begin
            e1_r[j] <= 33'($signed(rd_pos_r[j*POS_W +: POS_W])) - 33'(pa_r[j]);
          end
          s1_r    <= 25'($signed(rd_tex_r[TEX_W-1:0])) - 25'(ua_r);
          t1_r    <= 25'($signed(rd_tex_r[2*TEX_W-1:TEX_W])) - 25'(va_r);
          state_r <= S_FC;
        end
        S_FC: begin
          for (int j = 0; j < 3; j++) begin
            e2_r[j] <= 33'($signed(rd_pos_r[j*POS_W +: POS_W])) - 33'(pa_r[j]);
          end
          s2_r    <= 25'($signed(rd_tex_r[TEX_W-1:0])) - 25'(ua_r);
          t2_r    <= 25'($signed(rd_tex_r[2*TEX_W-1:TEX_W])) - 25'(va_r);
          state_r <= S_FDEN1;
        end
        S_FDEN1: begin
          p1_r    <= s1_r * t2_r;
          p2_r    <= s2_r * t1_r;
          state_r <= S_FDEN2;
        end
        S_FDEN2: begin
          den_r   <= den_c;
          k_r     <= '0;
          state_r <= (den_c == '0) ? S_IDLE : S_FNUM1;
        end
        S_FNUM1: begin
          mn1_r   <= t2_r * e1_r[k_r];
          mn2_r   <= t1_r * e2_r[k_r];
          state_r <= S_FNUM2;
        end
        S_FNUM2: begin
          neg_r   <= num_c[58] ^ den_r[50];
          state_r <= S_FDIV;
        end
        S_FDIV: begin
          if (div_done) begin
            dir_r[k_r] <= dir_c;
            if (k_r == 2'd2) begin
              k_r     <= '0;
              state_r <= S_FACC_RD;
            end else begin
              k_r     <= k_r + 1'b1;
              state_r <= S_FNUM1;
            end
          end
        end
        S_FACC_RD: state_r <= S_FACC_WR;
        S_FACC_WR: begin
          if (k_r == 2'd2) begin
            k_r     <= '0;
            state_r <= S_IDLE;
          end else begin
            k_r     <= k_r + 1'b1;
            state_r <= S_FACC_RD;
          end
        end
        S_RD: begin
          for (int j = 0; j < 3; j++) begin
            t_r[j] <= $signed(rd_acc_r[j*ACC_W +: ACC_W]);
            n_r[j] <= $signed(rd_nrm_r[j*NRM_W +: NRM_W]);
          end
          dacc_r <= '0;
          k_r    <= '0;
          if (rd_acc_r == '0) begin
            for (int j = 0; j < 3; j++) res_r[j] <= '0;
            zero_r  <= 1'b1;
            state_r <= S_OUT;
          end else begin
            state_r <= S_RDOT;
          end
        end
        S_RDOT: begin
          dacc_r <= dacc_r + 52'(prod_c >>> 14);
          if (k_r == 2'd2) begin
            k_r     <= '0;
            state_r <= S_RDCL;
          end else begin
            k_r <= k_r + 1'b1;
          end
        end
        S_RDCL: begin
          d_r     <= sat48(53'(dacc_r));
          state_r <= S_RPRJ;
        end
        S_RPRJ: begin
          o_r[k_r] <= 51'(t_r[k_r]) - 51'(proj_c >>> 14);
          if (k_r == 2'd2) begin
            k_r     <= '0;
            state_r <= S_RMAX;
          end else begin
            k_r <= k_r + 1'b1;
          end
        end
        S_RMAX: begin
          for (int j = 0; j < 3; j++) m_r[j] <= o_r[j][50] ? -o_r[j] : o_r[j];
          state_r <= S_RNRM;
        end
        S_RNRM: begin
          // One normalizing shift per cycle until the largest lies in [2^29, 2^30).
          if (mx == '0) begin
            for (int j = 0; j < 3; j++) res_r[j] <= '0;
            zero_r  <= 1'b1;
            state_r <= S_OUT;
          end else if (|mx[50:30]) begin
            for (int j = 0; j < 3; j++) m_r[j] <= m_r[j] >> 1;
          end else if (!mx[29]) begin
            for (int j = 0; j < 3; j++) m_r[j] <= m_r[j] << 1;
          end else begin
            sum_r   <= '0;
            k_r     <= '0;
            state_r <= S_RSQ;
          end
        end
        S_RSQ: begin
          sum_r <= sum_r + 62'(m_r[k_r][29:0] * m_r[k_r][29:0]);
          if (k_r == 2'd2) begin
            k_r     <= '0;
            state_r <= S_RSQRT_S;
          end else begin
            k_r <= k_r + 1'b1;
          end
        end
        S_RSQRT_S: state_r <= S_RSQRT_W;
        S_RSQRT_W: begin
          if (sq_done) begin
            len_r   <= sq_root;
            k_r     <= '0;
            state_r <= S_RDIVS;
          end
        end
        S_RDIVS: state_r <= S_RDIVW;
        S_RDIVW: begin
          if (div_done) begin
            res_r[k_r] <= o_r[k_r][50] ? -div_q[TAN_W-1:0] : div_q[TAN_W-1:0];
            if (k_r == 2'd2) begin
              k_r     <= '0;
              zero_r  <= 1'b0;
              state_r <= S_OUT;
            end else begin
              k_r     <= k_r + 1'b1;
              state_r <= S_RDIVS;
            end
          end
        end
        S_OUT: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            out_idx_r   <= vidx_r;
            for (int j = 0; j < 3; j++) out_tan_r[j] <= res_r[j];
            out_zero_r  <= zero_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_vert_index = out_idx_r;
  assign out_tan_x      = out_tan_r[0];
  assign out_tan_y      = out_tan_r[1];
  assign out_tan_z      = out_tan_r[2];
  assign out_is_zero    = out_zero_r;

endmodule

// ===== design/mesh_tangent_generator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mesh_tangent_generator: per-vertex tangent generation in fixed point
// Stores vertices, accumulates face tangents and reports orthonormalized
// per-vertex tangents.
// ----------------------------------------------------------------------------
// After reset the block clears the tangent accumulators, one entry per cycle,
// and holds in_ready low meanwhile. Every kept beat then goes into a two-entry
// command queue, so while the queue has room the input side keeps accepting
// while the sequencer works or while a finished result waits on the output
// register. A vertex load is written to the stores as it is popped. A face
// takes three store reads, the determinant, and one pass of the shared
// bit-serial divider for each of the three direction components, then a
// read-modify-write of the three corner accumulators; a zero determinant ends
// the face before any divider pass. A tangent read's time is set by the square
// root and three more divider passes plus up to 29 normalizing shift steps;
// a zero tangent or an index out of range is answered without the square
// root or the divider. Unused function codes and out-of-range loads
// and faces are accepted and dropped.
module mesh_tangent_generator #(
  parameter int VERTS = 4096
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [1:0]                         in_func,
  input  logic [mtg_pkg::IDX_W-1:0]          in_idx_a,
  input  logic [mtg_pkg::IDX_W-1:0]          in_idx_b,
  input  logic [mtg_pkg::IDX_W-1:0]          in_idx_c,
  input  logic signed [mtg_pkg::POS_W-1:0]   in_pos_x,
  input  logic signed [mtg_pkg::POS_W-1:0]   in_pos_y,
  input  logic signed [mtg_pkg::POS_W-1:0]   in_pos_z,
  input  logic signed [mtg_pkg::TEX_W-1:0]   in_tex_u,
  input  logic signed [mtg_pkg::TEX_W-1:0]   in_tex_v,
  input  logic signed [mtg_pkg::NRM_W-1:0]   in_nrm_x,
  input  logic signed [mtg_pkg::NRM_W-1:0]   in_nrm_y,
  input  logic signed [mtg_pkg::NRM_W-1:0]   in_nrm_z,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [mtg_pkg::IDX_W-1:0]          out_vert_index,
  output logic signed [mtg_pkg::TAN_W-1:0]   out_tan_x,
  output logic signed [mtg_pkg::TAN_W-1:0]   out_tan_y,
  output logic signed [mtg_pkg::TAN_W-1:0]   out_tan_z,
  output logic                               out_is_zero
);
  import mtg_pkg::*;

  // Queue head and the handshake between the front end and the sequencer.
  logic q_valid, q_pop, clear_busy;
  cmd_t q_cmd;

  // The front end range-checks indexes so the sequencer never sees a bad one
  // except as an explicit zero-tangent read.
  mtg_front #(.VERTS(VERTS)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_func    (in_func),
    .in_idx_a   (in_idx_a),
    .in_idx_b   (in_idx_b),
    .in_idx_c   (in_idx_c),
    .in_pos_x   (in_pos_x),
    .in_pos_y   (in_pos_y),
    .in_pos_z   (in_pos_z),
    .in_tex_u   (in_tex_u),
    .in_tex_v   (in_tex_v),
    .in_nrm_x   (in_nrm_x),
    .in_nrm_y   (in_nrm_y),
    .in_nrm_z   (in_nrm_z),
    .clear_busy (clear_busy),
    .q_valid    (q_valid),
    .q_cmd      (q_cmd),
    .q_pop      (q_pop)
  );

  // The sequencer owns all vertex stores and the result register.
  mtg_back #(.VERTS(VERTS)) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .q_cmd          (q_cmd),
    .q_pop          (q_pop),
    .clear_busy     (clear_busy),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_vert_index (out_vert_index),
    .out_tan_x      (out_tan_x),
    .out_tan_y      (out_tan_y),
    .out_tan_z      (out_tan_z),
    .out_is_zero    (out_is_zero)
  );

endmodule
